// File: rtl/c2eq_pkg.sv
`timescale 1ns / 1ps
// Package for the equirectangular UV block: payload structs, CORDIC angle table.
// No dependencies.
package c2eq_pkg;

  localparam int CoordBits   = 24;
  localparam int UvFracBits  = 16;
  localparam int CordicSteps = 30;
  localparam int AccBits     = 64;
  localparam int AngBits     = 36;
  localparam logic [31:0] InvGainQ32 = 32'd2608131496;

  typedef struct packed {
    logic signed [CoordBits-1:0] x_coord;
    logic signed [CoordBits-1:0] y_coord;
    logic signed [CoordBits-1:0] z_coord;
  } vertex_t;

  typedef struct packed {
    logic [UvFracBits-1:0] tex_u;
    logic [UvFracBits:0]   tex_v;
    logic                  at_origin;
  } uv_t;

  function automatic logic [31:0] turn_angle(input int idx);
    logic [31:0] a;
    begin
      case (idx)
        0: a = 32'd536870912;  1: a = 32'd316933406;  2: a = 32'd167458907;
        3: a = 32'd85004756;   4: a = 32'd42667331;   5: a = 32'd21354465;
        6: a = 32'd10679838;   7: a = 32'd5340245;    8: a = 32'd2670163;
        9: a = 32'd1335087;   10: a = 32'd667544;    11: a = 32'd333772;
        12: a = 32'd166886;   13: a = 32'd83443;     14: a = 32'd41722;
        15: a = 32'd20861;    16: a = 32'd10430;     17: a = 32'd5215;
        18: a = 32'd2608;     19: a = 32'd1304;      20: a = 32'd652;
        21: a = 32'd326;      22: a = 32'd163;       23: a = 32'd81;
        24: a = 32'd41;       25: a = 32'd20;        26: a = 32'd10;
        27: a = 32'd5;        28: a = 32'd3;         29: a = 32'd1;
        default: a = 32'd0;
      endcase
      return a;
    end
  endfunction

endpackage

// File: rtl/cartesian_to_equirect_uv.sv
`timescale 1ns / 1ps
// Top level: vertex to equirectangular texture coordinates.
// Depends on c2eq_pkg.
//
// Usage: drive vertex_i and raise start_i; a beat is taken on any edge with
// start_i high (busy_o is always low, one vertex per cycle). The result shows
// on uv_o with done_o high for one cycle, after passing through an input
// register, two 30-stage CORDIC vectoring pipelines, a gain multiply and
// u rounding stage and a v rounding stage, in that order.
// Throughput is one vertex per clock.
// Reset clears all valid bits; items in flight are dropped. The receiver
// cannot stall, so no backpressure exists; done_o marks each result beat.
// Origin input gives u = 0, v = one half and at_origin set.
// Points on the z axis give u = 0 with v from the second pass.
// A u that rounds up to one wraps to zero.
// Coordinates are prescaled to 58 bits of range before the passes.
// Angles are carried in binary turns.
// Results keep input order.
module cartesian_to_equirect_uv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  c2eq_pkg::vertex_t vertex_i,
  output logic              busy_o,
  output logic              done_o,
  output c2eq_pkg::uv_t     uv_o
);

  localparam int COORD_BITS   = c2eq_pkg::CoordBits;
  localparam int UV_FRAC_BITS = c2eq_pkg::UvFracBits;
  localparam int N  = c2eq_pkg::CordicSteps;
  localparam int W  = c2eq_pkg::AccBits;
  localparam int AW = c2eq_pkg::AngBits;
  localparam int PreShift = 58 - COORD_BITS;

  typedef struct packed {
    logic signed [W-1:0]  a;
    logic signed [W-1:0]  b;
    logic signed [AW-1:0] ang;
    logic signed [W-1:0]  z;
    logic                 org;
    logic                 axis;
  } p1_t;

  typedef struct packed {
    logic signed [W-1:0]  a;
    logic signed [W-1:0]  b;
    logic signed [AW-1:0] ang;
    logic [UV_FRAC_BITS-1:0] u;
    logic                 org;
  } p2_t;

  assign busy_o = 1'b0;

  logic signed [W-1:0] xs, ys, zs;
  p1_t s0_d;
  always_comb begin
    xs = W'(signed'(vertex_i.x_coord)) <<< PreShift;
    ys = W'(signed'(vertex_i.y_coord)) <<< PreShift;
    zs = W'(signed'(vertex_i.z_coord)) <<< PreShift;
    s0_d.org  = (vertex_i.x_coord == '0) && (vertex_i.y_coord == '0)
             && (vertex_i.z_coord == '0);
    s0_d.axis = (vertex_i.x_coord == '0) && (vertex_i.y_coord == '0);
    s0_d.z    = zs;
    if (xs < 0) begin
      s0_d.a   = -xs;
      s0_d.b   = -ys;
      s0_d.ang = AW'(64'sd2147483648);
    end else begin
      s0_d.a   = xs;
      s0_d.b   = ys;
      s0_d.ang = '0;
    end
  end

  p1_t       p1_q [N+1];
  logic [N:0] v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q[0] <= 1'b0;
    end else begin
      v1_q[0] <= start_i;
    end
  end
  always_ff @(posedge clk_i) begin
    p1_q[0] <= s0_d;
  end

  for (genvar i = 0; i < N; i++) begin : g_pass1
    p1_t st_d;
    always_comb begin
      st_d = p1_q[i];
      if (p1_q[i].b >= 0) begin
        st_d.a   = p1_q[i].a + (p1_q[i].b >>> i);
        st_d.b   = p1_q[i].b - (p1_q[i].a >>> i);
        st_d.ang = p1_q[i].ang + AW'(c2eq_pkg::turn_angle(i));
      end else begin
        st_d.a   = p1_q[i].a - (p1_q[i].b >>> i);
        st_d.b   = p1_q[i].b + (p1_q[i].a >>> i);
        st_d.ang = p1_q[i].ang - AW'(c2eq_pkg::turn_angle(i));
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v1_q[i+1] <= 1'b0;
      end else begin
        v1_q[i+1] <= v1_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      p1_q[i+1] <= st_d;
    end
  end

  // gain removal and u rounding
  logic [29:0] magh;
  logic [61:0] rprod;
  logic [31:0] tturn;
  logic [32:0] usum;
  p2_t s1_d;
  always_comb begin
    magh  = 30'(p1_q[N].a >>> 30);
    rprod = 62'(magh) * 62'(c2eq_pkg::InvGainQ32);
    tturn = 32'(p1_q[N].ang);
    usum  = 33'(tturn) + 33'(33'd1 << (31 - UV_FRAC_BITS));
    s1_d.org = p1_q[N].org;
    s1_d.b   = p1_q[N].z;
    s1_d.ang = '0;
    if (p1_q[N].axis) begin
      s1_d.a = '0;
      s1_d.u = '0;
    end else begin
      s1_d.a = W'(rprod >> 2);
      s1_d.u = usum[31 -: UV_FRAC_BITS];
    end
  end

  p2_t       p2_q [N+1];
  logic [N:0] v2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q[0] <= 1'b0;
    end else begin
      v2_q[0] <= v1_q[N];
    end
  end
  always_ff @(posedge clk_i) begin
    p2_q[0] <= s1_d;
  end

  for (genvar i = 0; i < N; i++) begin : g_pass2
    p2_t st_d;
    always_comb begin
      st_d = p2_q[i];
      if (p2_q[i].b >= 0) begin
        st_d.a   = p2_q[i].a + (p2_q[i].b >>> i);
        st_d.b   = p2_q[i].b - (p2_q[i].a >>> i);
        st_d.ang = p2_q[i].ang + AW'(c2eq_pkg::turn_angle(i));
      end else begin
        st_d.a   = p2_q[i].a - (p2_q[i].b >>> i);
        st_d.b   = p2_q[i].b + (p2_q[i].a >>> i);
        st_d.ang = p2_q[i].ang - AW'(c2eq_pkg::turn_angle(i));
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v2_q[i+1] <= 1'b0;
      end else begin
        v2_q[i+1] <= v2_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      p2_q[i+1] <= st_d;
    end
  end

  // v rounding and clamp
  logic signed [AW+1:0] vt, vsh;
  c2eq_pkg::uv_t res_d, res_q;
  logic          done_q;
  always_comb begin
    vt  = ((AW+2)'(p2_q[N].ang) <<< 1) + (AW+2)'(64'sd2147483648)
        + (AW+2)'(64'sd1 <<< (31 - UV_FRAC_BITS));
    vsh = vt >>> (32 - UV_FRAC_BITS);
    res_d.at_origin = p2_q[N].org;
    if (p2_q[N].org) begin
      res_d.tex_u = '0;
      res_d.tex_v = (UV_FRAC_BITS+1)'(1) << (UV_FRAC_BITS - 1);
    end else begin
      res_d.tex_u = p2_q[N].u;
      if (vsh < 0) begin
        res_d.tex_v = '0;
      end else if (vsh > ((AW+2)'(1) <<< UV_FRAC_BITS)) begin
        res_d.tex_v = (UV_FRAC_BITS+1)'(1) << UV_FRAC_BITS;
      end else begin
        res_d.tex_v = vsh[UV_FRAC_BITS:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v2_q[N];
    end
  end
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign uv_o   = res_q;

endmodule
